### design/ptu2d_pkg.sv
// ptu2d_pkg: shared constants of the 2D pose transform unit.
// Command and status codes, fixed-point formats, divider geometry.
// No dependencies.
`default_nettype none

package ptu2d_pkg;

	localparam logic [1:0] CMD_LERP     = 2'd0;
	localparam logic [1:0] CMD_TO_WORLD = 2'd1;
	localparam logic [1:0] CMD_TO_LOCAL = 2'd2;
	localparam logic [1:0] CMD_INVERSE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;

	localparam int SCALE_FRAC_BITS = 8;

	// divider: magnitude numerator, 16-bit magnitude divisor, 32-bit quotient
	localparam int DIV_NUM_W = 51;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_QUO_W = 32;
	localparam int DIV_LAT   = DIV_QUO_W + 1;

endpackage

`default_nettype wire

### design/ptu2d_div.sv
// ptu2d_div: pipelined restoring divider, one quotient bit per stage.
// Flags quotients that do not fit DIV_QUO_W bits. Depends on ptu2d_pkg.
`default_nettype none

module ptu2d_div import ptu2d_pkg::*; (
	input  logic                 clk,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_QUO_W-1:0] quo,
	output logic                 big
);

	logic [DIV_NUM_W-1:0] rem_s [0:DIV_QUO_W];
	logic [DIV_DEN_W-1:0] den_s [0:DIV_QUO_W];
	logic [DIV_QUO_W-1:0] quo_s [0:DIV_QUO_W];
	logic                 big_s [0:DIV_QUO_W];

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		big_s[0] <= (den != '0) &&
			(num >= DIV_NUM_W'({den, {DIV_QUO_W{1'b0}}}));
	end

	for (genvar k = 1; k <= DIV_QUO_W; k++) begin : g_step
		localparam int SH = DIV_QUO_W - k;
		logic [DIV_NUM_W:0] trial;

		assign trial = {1'b0, rem_s[k-1]} - ((DIV_NUM_W+1)'(den_s[k-1]) << SH);

		always_ff @(posedge clk) begin
			den_s[k] <= den_s[k-1];
			big_s[k] <= big_s[k-1];
			if (!trial[DIV_NUM_W]) begin
				rem_s[k] <= trial[DIV_NUM_W-1:0];
				quo_s[k] <= {quo_s[k-1][DIV_QUO_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= rem_s[k-1];
				quo_s[k] <= {quo_s[k-1][DIV_QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[DIV_QUO_W];
	assign big = big_s[DIV_QUO_W];

endmodule

`default_nettype wire

### design/pose_transform_unit_2d.sv
// pose_transform_unit_2d: lerp, compose, decompose and invert of 2D poses.
// Accepts one item per cycle; busy is always low.
// The depth is set by the 32-stage dividers behind the sine polynomial stages.
// Results cannot be held off; done pulses once per item.
// arst_n clears the valid chain only; datapath registers are not reset.
// Depends on ptu2d_pkg and ptu2d_div.
`default_nettype none

module pose_transform_unit_2d import ptu2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] a_trans_x,
	input  logic signed [31:0] a_trans_y,
	input  logic [15:0]        a_rot,
	input  logic signed [15:0] a_scale_x,
	input  logic signed [15:0] a_scale_y,
	input  logic signed [31:0] b_trans_x,
	input  logic signed [31:0] b_trans_y,
	input  logic [15:0]        b_rot,
	input  logic signed [15:0] b_scale_x,
	input  logic signed [15:0] b_scale_y,
	input  logic [16:0]        fraction,
	output logic               done,
	output logic signed [31:0] out_trans_x,
	output logic signed [31:0] out_trans_y,
	output logic [15:0]        out_rot,
	output logic signed [15:0] out_scale_x,
	output logic signed [15:0] out_scale_y,
	output logic [1:0]         status
);

	localparam int PIPE_LAT = 9 + DIV_LAT;
	localparam logic [16:0] Q16_ONE = 17'h10000;
	localparam logic [16:0] POLY_C0 = 17'd11;
	localparam logic [16:0] POLY_C1 = 17'd307;
	localparam logic [16:0] POLY_C2 = 17'd5223;
	localparam logic [16:0] POLY_C3 = 17'd42334;
	localparam logic [16:0] POLY_C4 = 17'd102944;
	localparam int D_SX = 0;
	localparam int D_SY = 1;
	localparam int D_TX = 2;
	localparam int D_TY = 3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] atx;
		logic [31:0] aty;
		logic [31:0] btx;
		logic [31:0] bty;
		logic [15:0] arot;
		logic [15:0] brot;
		logic [15:0] asx;
		logic [15:0] asy;
		logic [15:0] bsx;
		logic [15:0] bsy;
		logic [1:0]  quad;
	} base_t;

	typedef struct packed {
		logic [16:0] x;
		logic [16:0] x2;
		logic [16:0] t;
	} trig_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] atx;
		logic [31:0] aty;
		logic [15:0] asx;
		logic [15:0] asy;
		logic [15:0] bsx;
		logic [15:0] bsy;
		logic [1:0]  quad;
		logic [15:0] rot;
		logic [31:0] tx;
		logic [31:0] ty;
		logic [15:0] sx;
		logic [15:0] sy;
		logic        ovf;
		logic [39:0] px;
		logic [39:0] py;
	} ctx_t;

	typedef struct packed {
		logic den_zero;
		logic num_pos;
		logic num_neg;
		logic neg;
	} dctl_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [15:0]     rot;
		logic [31:0]     tx;
		logic [31:0]     ty;
		logic [15:0]     sx;
		logic [15:0]     sy;
		logic            ovf;
		dctl_t [3:0]     ctl;
	} fin_t;

	typedef struct packed {
		logic [31:0] v;
		logic        o;
	} sat32_t;

	typedef struct packed {
		logic [15:0] v;
		logic        o;
	} sat16_t;

	typedef struct packed {
		logic [31:0] v;
		logic        dz;
		logic        o;
	} fix_t;

	function automatic sat32_t sat32(input logic signed [63:0] v);
		sat32_t r;
		if (v > 64'sh7FFFFFFF) begin
			r.v = 32'h7FFFFFFF;
			r.o = 1'b1;
		end else if (v < -64'sh80000000) begin
			r.v = 32'h80000000;
			r.o = 1'b1;
		end else begin
			r.v = v[31:0];
			r.o = 1'b0;
		end
		return r;
	endfunction

	function automatic sat16_t sat16(input logic signed [63:0] v);
		sat16_t r;
		if (v > 64'sh7FFF) begin
			r.v = 16'h7FFF;
			r.o = 1'b1;
		end else if (v < -64'sh8000) begin
			r.v = 16'h8000;
			r.o = 1'b1;
		end else begin
			r.v = v[15:0];
			r.o = 1'b0;
		end
		return r;
	endfunction

	function automatic trig_t poly_step(input trig_t a, input logic [16:0] c);
		logic [33:0] p;
		trig_t r;
		p = 34'(a.t) * 34'(a.x2);
		r = a;
		r.t = 17'(34'(c) - (p >> 16));
		return r;
	endfunction

	function automatic logic [DIV_NUM_W-1:0] mag_of(input logic signed [63:0] n);
		logic [63:0] m;
		m = n[63] ? (~n + 64'd1) : n;
		return m[DIV_NUM_W-1:0];
	endfunction

	function automatic logic [DIV_DEN_W-1:0] den_of(input logic [15:0] d);
		return d[15] ? (~d + 16'd1) : d;
	endfunction

	function automatic dctl_t mk_ctl(input logic signed [63:0] n, input logic [15:0] d);
		dctl_t r;
		r.den_zero = (d == 16'd0);
		r.num_pos  = !n[63] && (n != 64'sd0);
		r.num_neg  = n[63];
		r.neg      = n[63] ^ d[15];
		return r;
	endfunction

	function automatic fix_t div_fix(input dctl_t c, input logic [31:0] q,
			input logic big, input logic is32);
		logic [31:0] hi;
		logic [31:0] lo;
		fix_t r;
		hi = is32 ? 32'h7FFFFFFF : 32'h00007FFF;
		lo = is32 ? 32'h80000000 : 32'hFFFF8000;
		r.dz = 1'b0;
		r.o  = 1'b0;
		if (c.den_zero) begin
			r.dz = 1'b1;
			r.v  = c.num_pos ? hi : (c.num_neg ? lo : 32'd0);
		end else if (!c.neg) begin
			if (big || q > hi) begin
				r.v = hi;
				r.o = 1'b1;
			end else begin
				r.v = q;
			end
		end else begin
			if (big || q > (32'd0 - lo)) begin
				r.v = lo;
				r.o = 1'b1;
			end else begin
				r.v = 32'd0 - q;
			end
		end
		return r;
	endfunction

	// s1: input capture
	logic [PIPE_LAT-1:0] vld_s;
	base_t               base_s1;
	logic [16:0]         frac_s1;
	logic [16:0]         x_s1 [2];
	logic [16:0]         xa;

	assign busy = 1'b0;
	assign xa = {1'b0, a_rot[13:0], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done  <= 1'b0;
		end else begin
			vld_s <= {vld_s[PIPE_LAT-2:0], start};
			done  <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= '{cmd: command, atx: a_trans_x, aty: a_trans_y,
			btx: b_trans_x, bty: b_trans_y, arot: a_rot, brot: b_rot,
			asx: a_scale_x, asy: a_scale_y, bsx: b_scale_x, bsy: b_scale_y,
			quad: a_rot[15:14]};
		frac_s1 <= (fraction > Q16_ONE) ? Q16_ONE : fraction;
		x_s1[0] <= xa;
		x_s1[1] <= Q16_ONE - xa;
	end

	// s2: products; sine polynomial steps (trg_s2 to trg_s6)
	base_t              base_s2;
	logic signed [50:0] m_tx_s2, m_ty_s2;
	logic signed [34:0] m_rot_s2, m_sx_s2, m_sy_s2;
	logic signed [31:0] m_psx_s2, m_psy_s2;
	logic signed [47:0] m_px_s2, m_py_s2;
	logic signed [17:0] fs;
	logic [33:0]        sq_w [2];
	trig_t              trg_s2 [2];
	trig_t              trg_s3 [2];
	trig_t              trg_s4 [2];
	trig_t              trg_s5 [2];
	trig_t              trg_s6 [2];

	assign fs = $signed({1'b0, frac_s1});

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sq_w[l] = 34'(x_s1[l]) * 34'(x_s1[l]);
		end
	end

	always_ff @(posedge clk) begin
		base_s2  <= base_s1;
		m_tx_s2  <= ($signed(base_s1.btx) - $signed(base_s1.atx)) * fs;
		m_ty_s2  <= ($signed(base_s1.bty) - $signed(base_s1.aty)) * fs;
		m_rot_s2 <= ($signed({1'b0, base_s1.brot}) - $signed({1'b0, base_s1.arot})) * fs;
		m_sx_s2  <= ($signed(base_s1.bsx) - $signed(base_s1.asx)) * fs;
		m_sy_s2  <= ($signed(base_s1.bsy) - $signed(base_s1.asy)) * fs;
		m_psx_s2 <= $signed(base_s1.asx) * $signed(base_s1.bsx);
		m_psy_s2 <= $signed(base_s1.asy) * $signed(base_s1.bsy);
		m_px_s2  <= $signed(base_s1.btx) * $signed(base_s1.asx);
		m_py_s2  <= $signed(base_s1.bty) * $signed(base_s1.asy);
		for (int l = 0; l < 2; l++) begin
			trg_s2[l] <= '{x: x_s1[l], x2: sq_w[l][32:16], t: POLY_C0};
			trg_s3[l] <= poly_step(trg_s2[l], POLY_C1);
			trg_s4[l] <= poly_step(trg_s3[l], POLY_C2);
			trg_s5[l] <= poly_step(trg_s4[l], POLY_C3);
			trg_s6[l] <= poly_step(trg_s5[l], POLY_C4);
		end
	end

	// s3: per-command pose terms
	ctx_t               c3;
	ctx_t               ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8;
	sat32_t             l_tx, l_ty, n_tx, n_ty;
	sat16_t             l_sx, l_sy, p_sx, p_sy;
	logic signed [47:0] pxw, pyw;
	logic signed [39:0] dxw, dyw;

	always_comb begin
		l_tx = sat32($signed(base_s2.atx) + (m_tx_s2 >>> 16));
		l_ty = sat32($signed(base_s2.aty) + (m_ty_s2 >>> 16));
		l_sx = sat16($signed(base_s2.asx) + (m_sx_s2 >>> 16));
		l_sy = sat16($signed(base_s2.asy) + (m_sy_s2 >>> 16));
		p_sx = sat16(m_psx_s2 >>> SCALE_FRAC_BITS);
		p_sy = sat16(m_psy_s2 >>> SCALE_FRAC_BITS);
		n_tx = sat32(-$signed(base_s2.atx));
		n_ty = sat32(-$signed(base_s2.aty));
		pxw  = m_px_s2 >>> SCALE_FRAC_BITS;
		pyw  = m_py_s2 >>> SCALE_FRAC_BITS;
		dxw  = $signed(base_s2.btx) - $signed(base_s2.atx);
		dyw  = $signed(base_s2.bty) - $signed(base_s2.aty);

		c3      = '0;
		c3.cmd  = base_s2.cmd;
		c3.atx  = base_s2.atx;
		c3.aty  = base_s2.aty;
		c3.asx  = base_s2.asx;
		c3.asy  = base_s2.asy;
		c3.bsx  = base_s2.bsx;
		c3.bsy  = base_s2.bsy;
		c3.quad = base_s2.quad;
		case (base_s2.cmd)
			CMD_LERP: begin
				c3.tx  = l_tx.v;
				c3.ty  = l_ty.v;
				c3.sx  = l_sx.v;
				c3.sy  = l_sy.v;
				c3.rot = 16'($signed({1'b0, base_s2.arot}) + (m_rot_s2 >>> 16));
				c3.ovf = l_tx.o | l_ty.o | l_sx.o | l_sy.o;
			end
			CMD_TO_WORLD: begin
				c3.sx  = p_sx.v;
				c3.sy  = p_sy.v;
				c3.ovf = p_sx.o | p_sy.o;
				c3.rot = base_s2.arot + base_s2.brot;
				c3.px  = pxw[39:0];
				c3.py  = pyw[39:0];
			end
			CMD_TO_LOCAL: begin
				c3.rot = base_s2.brot - base_s2.arot;
				c3.px  = dxw;
				c3.py  = dyw;
			end
			CMD_INVERSE: begin
				c3.tx  = n_tx.v;
				c3.ty  = n_ty.v;
				c3.ovf = n_tx.o | n_ty.o;
				c3.rot = 16'd0 - base_s2.arot;
			end
			default: begin
				c3.rot = base_s2.arot;
			end
		endcase
	end

	// s7: sine and cosine from the quadrant
	logic [33:0]        tp_w [2];
	logic [16:0]        tq_w [2];
	logic signed [17:0] sp, cp, sin_w, cos_w;
	logic signed [17:0] sin_s7, cos_s7;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			tp_w[l] = 34'(trg_s6[l].t) * 34'(trg_s6[l].x);
			tq_w[l] = ((tp_w[l] >> 16) > 34'(Q16_ONE)) ? Q16_ONE : tp_w[l][32:16];
		end
		sp = $signed({1'b0, tq_w[0]});
		cp = $signed({1'b0, tq_w[1]});
		case (ctx_s6.quad)
			2'd0: begin
				sin_w = sp;
				cos_w = cp;
			end
			2'd1: begin
				sin_w = cp;
				cos_w = -sp;
			end
			2'd2: begin
				sin_w = -sp;
				cos_w = -cp;
			end
			default: begin
				sin_w = -cp;
				cos_w = sp;
			end
		endcase
	end

	// s8: rotation products
	logic signed [57:0] pc_s8, ps_s8, qs_s8, qc_s8;

	always_ff @(posedge clk) begin
		ctx_s3 <= c3;
		ctx_s4 <= ctx_s3;
		ctx_s5 <= ctx_s4;
		ctx_s6 <= ctx_s5;
		ctx_s7 <= ctx_s6;
		ctx_s8 <= ctx_s7;
		sin_s7 <= sin_w;
		cos_s7 <= cos_w;
		pc_s8  <= $signed(ctx_s7.px) * cos_s7;
		ps_s8  <= $signed(ctx_s7.py) * sin_s7;
		qs_s8  <= $signed(ctx_s7.px) * sin_s7;
		qc_s8  <= $signed(ctx_s7.py) * cos_s7;
	end

	// s9: world translation, divider operands
	sat32_t               w_tx, w_ty;
	logic signed [63:0]   utx, uty, ntx, nty, nsx, nsy;
	fin_t                 f9;
	fin_t                 fin_s9;
	logic [DIV_NUM_W-1:0] num_s9 [4];
	logic [DIV_DEN_W-1:0] den_s9 [4];
	logic                 is_w;

	always_comb begin
		is_w = (ctx_s8.cmd == CMD_TO_WORLD);
		w_tx = sat32(((pc_s8 - ps_s8) >>> 16) + $signed(ctx_s8.atx));
		w_ty = sat32(((qs_s8 + qc_s8) >>> 16) + $signed(ctx_s8.aty));
		utx  = (pc_s8 + ps_s8) >>> 16;
		uty  = (qc_s8 - qs_s8) >>> 16;
		ntx  = utx <<< SCALE_FRAC_BITS;
		nty  = uty <<< SCALE_FRAC_BITS;
		if (ctx_s8.cmd == CMD_INVERSE) begin
			nsx = 64'sd1 <<< (2 * SCALE_FRAC_BITS);
			nsy = 64'sd1 <<< (2 * SCALE_FRAC_BITS);
		end else begin
			nsx = $signed(ctx_s8.bsx) <<< SCALE_FRAC_BITS;
			nsy = $signed(ctx_s8.bsy) <<< SCALE_FRAC_BITS;
		end
		f9.cmd       = ctx_s8.cmd;
		f9.rot       = ctx_s8.rot;
		f9.tx        = is_w ? w_tx.v : ctx_s8.tx;
		f9.ty        = is_w ? w_ty.v : ctx_s8.ty;
		f9.sx        = ctx_s8.sx;
		f9.sy        = ctx_s8.sy;
		f9.ovf       = ctx_s8.ovf | (is_w & (w_tx.o | w_ty.o));
		f9.ctl[D_SX] = mk_ctl(nsx, ctx_s8.asx);
		f9.ctl[D_SY] = mk_ctl(nsy, ctx_s8.asy);
		f9.ctl[D_TX] = mk_ctl(ntx, ctx_s8.asx);
		f9.ctl[D_TY] = mk_ctl(nty, ctx_s8.asy);
	end

	always_ff @(posedge clk) begin
		fin_s9       <= f9;
		num_s9[D_SX] <= mag_of(nsx);
		num_s9[D_SY] <= mag_of(nsy);
		num_s9[D_TX] <= mag_of(ntx);
		num_s9[D_TY] <= mag_of(nty);
		den_s9[D_SX] <= den_of(ctx_s8.asx);
		den_s9[D_SY] <= den_of(ctx_s8.asy);
		den_s9[D_TX] <= den_of(ctx_s8.asx);
		den_s9[D_TY] <= den_of(ctx_s8.asy);
	end

	// dividers and the matching delay line
	logic [DIV_QUO_W-1:0] quo_w [4];
	logic                 big_w [4];
	fin_t                 dfin_s [DIV_LAT];

	for (genvar g = 0; g < 4; g++) begin : g_div
		ptu2d_div u_div (
			.clk (clk),
			.num (num_s9[g]),
			.den (den_s9[g]),
			.quo (quo_w[g]),
			.big (big_w[g])
		);
	end

	always_ff @(posedge clk) begin
		dfin_s[0] <= fin_s9;
		for (int k = 1; k < DIV_LAT; k++) begin
			dfin_s[k] <= dfin_s[k-1];
		end
	end

	// output stage
	fin_t fl;
	fix_t fx [4];
	logic use_dt, use_ds, dz, ovf;

	always_comb begin
		fl       = dfin_s[DIV_LAT-1];
		fx[D_SX] = div_fix(fl.ctl[D_SX], quo_w[D_SX], big_w[D_SX], 1'b0);
		fx[D_SY] = div_fix(fl.ctl[D_SY], quo_w[D_SY], big_w[D_SY], 1'b0);
		fx[D_TX] = div_fix(fl.ctl[D_TX], quo_w[D_TX], big_w[D_TX], 1'b1);
		fx[D_TY] = div_fix(fl.ctl[D_TY], quo_w[D_TY], big_w[D_TY], 1'b1);
		use_dt   = (fl.cmd == CMD_TO_LOCAL);
		use_ds   = use_dt || (fl.cmd == CMD_INVERSE);
		dz  = (use_ds & (fx[D_SX].dz | fx[D_SY].dz)) |
			(use_dt & (fx[D_TX].dz | fx[D_TY].dz));
		ovf = fl.ovf | (use_ds & (fx[D_SX].o | fx[D_SY].o)) |
			(use_dt & (fx[D_TX].o | fx[D_TY].o));
	end

	always_ff @(posedge clk) begin
		out_trans_x <= use_dt ? fx[D_TX].v : fl.tx;
		out_trans_y <= use_dt ? fx[D_TY].v : fl.ty;
		out_rot     <= fl.rot;
		out_scale_x <= use_ds ? fx[D_SX].v[15:0] : fl.sx;
		out_scale_y <= use_ds ? fx[D_SY].v[15:0] : fl.sy;
		status      <= dz ? ST_DIV_ZERO : (ovf ? ST_SAT : ST_OK);
	end

endmodule

`default_nettype wire

### tb/pose_transform_unit_2d_test.sv
// pose_transform_unit_2d_test: self-checking bench for the 2D pose transform unit.
// It drives directed and random items, predicts each result and checks it.
// Depends on ptu2d_pkg and pose_transform_unit_2d.
`timescale 1ns / 100ps

module pose_transform_unit_2d_test import ptu2d_pkg::*;;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [31:0] atx, aty, btx, bty;
		logic [15:0]        arot, brot;
		logic signed [15:0] asx, asy, bsx, bsy;
		logic [16:0]        frac;
	} pose_op_t;

	typedef struct {
		logic signed [31:0] tx, ty;
		logic [15:0]        rot;
		logic signed [15:0] sx, sy;
		logic [1:0]         st;
	} pose_res_t;

	localparam int LIMIT_CYCLES = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [1:0] command = '0;
	logic signed [31:0] a_trans_x = '0, a_trans_y = '0, b_trans_x = '0, b_trans_y = '0;
	logic [15:0] a_rot = '0, b_rot = '0;
	logic signed [15:0] a_scale_x = '0, a_scale_y = '0, b_scale_x = '0, b_scale_y = '0;
	logic [16:0] fraction = '0;
	logic signed [31:0] out_trans_x, out_trans_y;
	logic [15:0] out_rot;
	logic signed [15:0] out_scale_x, out_scale_y;
	logic [1:0] status;

	pose_op_t  pending_ops[$];
	pose_res_t expected_poses[$];
	int errors = 0;
	int cycles = 0;
	bit took = 1'b0;
	int gap_left = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	pose_transform_unit_2d u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.a_trans_x(a_trans_x), .a_trans_y(a_trans_y), .a_rot(a_rot),
		.a_scale_x(a_scale_x), .a_scale_y(a_scale_y),
		.b_trans_x(b_trans_x), .b_trans_y(b_trans_y), .b_rot(b_rot),
		.b_scale_x(b_scale_x), .b_scale_y(b_scale_y), .fraction(fraction),
		.done(done), .out_trans_x(out_trans_x), .out_trans_y(out_trans_y),
		.out_rot(out_rot), .out_scale_x(out_scale_x), .out_scale_y(out_scale_y),
		.status(status)
	);

	function automatic longint clamp(longint v, int bits, ref bit ovf);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) begin
			ovf = 1'b1;
			return hi;
		end
		if (v < -hi - 1) begin
			ovf = 1'b1;
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic longint quadrant_sine(longint unsigned x);
		longint unsigned x2, t;
		x2 = (x * x) >> 16;
		t = 11;
		t = 307 - ((t * x2) >> 16);
		t = 5223 - ((t * x2) >> 16);
		t = 42334 - ((t * x2) >> 16);
		t = 102944 - ((t * x2) >> 16);
		t = (t * x) >> 16;
		if (t > 65536)
			t = 65536;
		return longint'(t);
	endfunction

	function automatic void sine_cosine(input logic [15:0] ang, output longint s,
			output longint c);
		longint sp, cp;
		longint unsigned x;
		x = longint'(ang[13:0]) << 2;
		sp = quadrant_sine(x);
		cp = quadrant_sine(65536 - x);
		case (ang[15:14])
			2'd0: begin s = sp; c = cp; end
			2'd1: begin s = cp; c = -sp; end
			2'd2: begin s = -sp; c = -cp; end
			default: begin s = -cp; c = sp; end
		endcase
	endfunction

	function automatic longint safe_div(longint num, longint den, int bits,
			ref bit dz, ref bit ovf);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (den == 0) begin
			dz = 1'b1;
			if (num > 0)
				return hi;
			if (num < 0)
				return -hi - 1;
			return 0;
		end
		return clamp(num / den, bits, ovf);
	endfunction

	function automatic longint blend(longint a, longint b, longint f);
		return a + (((b - a) * f) >>> 16);
	endfunction

	function automatic pose_res_t predict_pose(pose_op_t op);
		pose_res_t r;
		longint one_s, f, tx, ty, sx, sy, s, c, px, py, rot;
		bit dz, ovf;
		one_s = longint'(1) <<< SCALE_FRAC_BITS;
		dz = 0;
		ovf = 0;
		f = op.frac;
		if (f > 65536)
			f = 65536;
		case (op.cmd)
			CMD_LERP: begin
				tx = clamp(blend(op.atx, op.btx, f), 32, ovf);
				ty = clamp(blend(op.aty, op.bty, f), 32, ovf);
				rot = blend(op.arot, op.brot, f);
				sx = clamp(blend(op.asx, op.bsx, f), 16, ovf);
				sy = clamp(blend(op.asy, op.bsy, f), 16, ovf);
			end
			CMD_TO_WORLD: begin
				sx = clamp((longint'(op.asx) * op.bsx) >>> SCALE_FRAC_BITS, 16, ovf);
				sy = clamp((longint'(op.asy) * op.bsy) >>> SCALE_FRAC_BITS, 16, ovf);
				rot = longint'(op.arot) + op.brot;
				px = (longint'(op.btx) * op.asx) >>> SCALE_FRAC_BITS;
				py = (longint'(op.bty) * op.asy) >>> SCALE_FRAC_BITS;
				sine_cosine(op.arot, s, c);
				tx = clamp(((px * c - py * s) >>> 16) + op.atx, 32, ovf);
				ty = clamp(((px * s + py * c) >>> 16) + op.aty, 32, ovf);
			end
			CMD_TO_LOCAL: begin
				sx = safe_div(longint'(op.bsx) * one_s, op.asx, 16, dz, ovf);
				sy = safe_div(longint'(op.bsy) * one_s, op.asy, 16, dz, ovf);
				rot = longint'(op.brot) - op.arot;
				px = longint'(op.btx) - op.atx;
				py = longint'(op.bty) - op.aty;
				sine_cosine(op.arot, s, c);
				tx = (px * c + py * s) >>> 16;
				ty = (py * c - px * s) >>> 16;
				tx = safe_div(tx * one_s, op.asx, 32, dz, ovf);
				ty = safe_div(ty * one_s, op.asy, 32, dz, ovf);
			end
			default: begin
				tx = clamp(-longint'(op.atx), 32, ovf);
				ty = clamp(-longint'(op.aty), 32, ovf);
				rot = -longint'(op.arot);
				sx = safe_div(one_s * one_s, op.asx, 16, dz, ovf);
				sy = safe_div(one_s * one_s, op.asy, 16, dz, ovf);
			end
		endcase
		r.tx = tx[31:0];
		r.ty = ty[31:0];
		r.rot = rot[15:0];
		r.sx = sx[15:0];
		r.sy = sy[15:0];
		r.st = dz ? ST_DIV_ZERO : (ovf ? ST_SAT : ST_OK);
		return r;
	endfunction

	function automatic logic [31:0] pick_trans();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3, 4: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(0, 11))
			0: return 16'h0;
			1: return 16'h8000;
			2: return 16'h7fff;
			3: return 16'h0100;
			4: return 16'hff00;
			5, 6, 7: return 16'($urandom_range(0, 1536)) - 16'd768;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1ffff;
			3: return 17'($urandom);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic pose_op_t random_op();
		pose_op_t op;
		op.cmd = 2'($urandom_range(0, 3));
		op.atx = pick_trans();
		op.aty = pick_trans();
		op.btx = pick_trans();
		op.bty = pick_trans();
		op.arot = 16'($urandom);
		op.brot = 16'($urandom);
		op.asx = pick_scale();
		op.asy = pick_scale();
		op.bsx = pick_scale();
		op.bsy = pick_scale();
		op.frac = pick_frac();
		return op;
	endfunction

	task automatic add_op(logic [1:0] cmd, logic [31:0] atx, logic [31:0] aty,
			logic [15:0] arot, logic [15:0] asx, logic [15:0] asy,
			logic [31:0] btx, logic [31:0] bty, logic [15:0] brot,
			logic [15:0] bsx, logic [15:0] bsy, logic [16:0] frac);
		pose_op_t op;
		op.cmd = cmd;
		op.atx = atx; op.aty = aty; op.arot = arot; op.asx = asx; op.asy = asy;
		op.btx = btx; op.bty = bty; op.brot = brot; op.bsx = bsx; op.bsy = bsy;
		op.frac = frac;
		pending_ops.push_back(op);
	endtask

	initial begin
		add_op(CMD_LERP, 0, 0, 0, 16'h100, 16'h100, 32'h10000, 32'h20000, 16'h4000,
			16'h200, 16'h300, 17'd32768);
		add_op(CMD_LERP, 32'h8000_0000, 32'h8000_0000, 16'hffff, 16'h8000, 16'h8000,
			32'h7fff_ffff, 32'h7fff_ffff, 0, 16'h7fff, 16'h7fff, 17'h1ffff);
		add_op(CMD_LERP, 32'h7fff_ffff, 32'h8000_0000, 0, 16'h7fff, 16'h8000,
			32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'h8000, 16'h7fff, 17'd65535);
		add_op(CMD_LERP, 5, -5, 16'h8000, 1, 2, 9, 9, 16'h0100, 3, 4, 17'd0);
		add_op(CMD_TO_WORLD, 32'h10000, 32'h20000, 0, 16'h100, 16'h100,
			32'h30000, 32'h40000, 16'h1000, 16'h100, 16'h100, 0);
		add_op(CMD_TO_WORLD, 32'h7fff_ffff, 32'h8000_0000, 16'h4000, 16'h7fff, 16'h8000,
			32'h7fff_ffff, 32'h8000_0000, 16'hc000, 16'h7fff, 16'h8000, 0);
		add_op(CMD_TO_WORLD, 0, 0, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000,
			32'h8000_0000, 16'hffff, 16'h8000, 16'h8000, 17'h1ffff);
		add_op(CMD_TO_WORLD, -100, 100, 16'hffff, 16'hff00, 16'h0080, 123456, -654321,
			16'h2000, 16'h0200, 16'hfe00, 0);
		add_op(CMD_TO_LOCAL, 32'h10000, 0, 16'h4000, 16'h100, 16'h200,
			32'h50000, 32'h30000, 16'h8000, 16'h300, 16'h100, 0);
		add_op(CMD_TO_LOCAL, 0, 0, 0, 0, 0, 32'h10000, 32'hffff0000, 0,
			16'h100, 16'hff00, 0);
		add_op(CMD_TO_LOCAL, 5, 7, 16'h1234, 0, 0, 5, 7, 16'h1234, 0, 0, 0);
		add_op(CMD_TO_LOCAL, 32'h8000_0000, 32'h7fff_ffff, 16'hc000, 16'h0001, 16'hffff,
			32'h7fff_ffff, 32'h8000_0000, 0, 16'h7fff, 16'h8000, 0);
		add_op(CMD_TO_LOCAL, 0, 0, 0, 16'h0001, 16'h0001, 0, 0, 0, 16'h7fff, 16'h8000, 0);
		add_op(CMD_INVERSE, 32'h8000_0000, 32'h8000_0000, 16'h0001, 16'h100, 16'h100,
			0, 0, 0, 0, 0, 0);
		add_op(CMD_INVERSE, 32'h7fff_ffff, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_op(CMD_INVERSE, 32'h12345, -32'h54321, 16'h8000, 16'h0001, 16'hffff,
			0, 0, 0, 0, 0, 0);
		add_op(CMD_INVERSE, 0, 0, 16'hffff, 16'h8000, 16'h7fff, 32'hffff_ffff,
			32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff);
		add_op(CMD_INVERSE, 1, -1, 16'h4000, 16'h0200, 16'hff80, 0, 0, 0, 0, 0, 0);
		repeat (1750)
			pending_ops.push_back(random_op());
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_ops.size() == 0 && !start && expected_poses.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// driver: bursts of back-to-back items separated by random gaps
	always @(negedge clk) begin
		pose_op_t op;
		bit drive;
		if (arst_n && !(start && !took)) begin
			drive = 1'b0;
			if (gap_left > 0)
				gap_left = gap_left - 1;
			else if (pending_ops.size() != 0) begin
				drive = 1'b1;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 40);
				burst_left = burst_left - 1;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (drive) begin
				op = pending_ops.pop_front();
				command <= op.cmd;
				a_trans_x <= op.atx;
				a_trans_y <= op.aty;
				a_rot <= op.arot;
				a_scale_x <= op.asx;
				a_scale_y <= op.asy;
				b_trans_x <= op.btx;
				b_trans_y <= op.bty;
				b_rot <= op.brot;
				b_scale_x <= op.bsx;
				b_scale_y <= op.bsy;
				fraction <= op.frac;
			end
			start <= drive;
		end
	end

	// monitor: record accepted items and check results
	always @(posedge clk) begin
		pose_op_t op;
		pose_res_t exp_pose;
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
		took = start && !busy && arst_n;
		if (took) begin
			op.cmd = command;
			op.atx = a_trans_x; op.aty = a_trans_y; op.arot = a_rot;
			op.asx = a_scale_x; op.asy = a_scale_y;
			op.btx = b_trans_x; op.bty = b_trans_y; op.brot = b_rot;
			op.bsx = b_scale_x; op.bsy = b_scale_y;
			op.frac = fraction;
			expected_poses.push_back(predict_pose(op));
		end
		if (arst_n && done) begin
			if (expected_poses.size() == 0) begin
				errors++;
				$display("%0t: result with none expected", $time);
			end else begin
				exp_pose = expected_poses.pop_front();
				if (out_trans_x !== exp_pose.tx) begin
					errors++;
					$display("%0t: trans_x exp %h got %h", $time, exp_pose.tx, out_trans_x);
				end
				if (out_trans_y !== exp_pose.ty) begin
					errors++;
					$display("%0t: trans_y exp %h got %h", $time, exp_pose.ty, out_trans_y);
				end
				if (out_rot !== exp_pose.rot) begin
					errors++;
					$display("%0t: rot exp %h got %h", $time, exp_pose.rot, out_rot);
				end
				if (out_scale_x !== exp_pose.sx) begin
					errors++;
					$display("%0t: scale_x exp %h got %h", $time, exp_pose.sx, out_scale_x);
				end
				if (out_scale_y !== exp_pose.sy) begin
					errors++;
					$display("%0t: scale_y exp %h got %h", $time, exp_pose.sy, out_scale_y);
				end
				if (status !== exp_pose.st) begin
					errors++;
					$display("%0t: status exp %h got %h", $time, exp_pose.st, status);
				end
			end
		end
	end

endmodule
